@@ sv/hctb_pkg.sv @@
// Shared types and constants for the Huffman code table builder.
// Holds command codes, datapath operations and the control/status structs.
// No dependencies.
package hctb_pkg;

	localparam int FUNC_W  = 2;
	localparam int SYM_W   = 8;
	localparam int FREQ_W  = 64;
	localparam int CODE_W  = 64;
	localparam int CLEN_W  = 7;
	localparam int LEN_W   = 8;

	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_BUILD = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_WR_FREQ,
		OP_INIT_START,
		OP_INIT,
		OP_MERGE_START,
		OP_SCAN,
		OP_WR_FIRST,
		OP_WR_SECOND,
		OP_WR_NEW,
		OP_WALK_START,
		OP_WALK_USE,
		OP_WALK_STORE,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		logic   capture;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic cnt_last;
		logic scan_last;
		logic merge_last;
		logic walk_root;
	} dp_stat_t;

endpackage

@@ sv/hctb_datapath.sv @@
// Datapath of the Huffman code table builder: node and code memories,
// ranking compare, merge writes and the leaf-to-root code walk.
// Depends on hctb_pkg.
module hctb_datapath #(
	parameter int SYMBOL_COUNT = 256,
	parameter int MAX_CODE_LEN = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hctb_pkg::dp_cmd_t             cmd,
	output hctb_pkg::dp_stat_t            stat,
	input  logic [hctb_pkg::SYM_W-1:0]    in_sym,
	input  logic [hctb_pkg::FREQ_W-1:0]   in_freq,
	output logic [hctb_pkg::CODE_W-1:0]   code_bits,
	output logic [hctb_pkg::CLEN_W-1:0]   code_length,
	output logic                          status
);
	import hctb_pkg::*;

	localparam int NODE_COUNT = 2 * SYMBOL_COUNT - 1;
	localparam int NW = $clog2(NODE_COUNT);
	localparam int SW = $clog2(SYMBOL_COUNT);
	localparam int ROOT = NODE_COUNT - 1;

	logic [FREQ_W-1:0] weight_mem [NODE_COUNT];
	logic [SYM_W-1:0]  minsym_mem [NODE_COUNT];
	logic              active_mem [NODE_COUNT];
	logic [NW:0]       pb_mem     [NODE_COUNT];
	logic [CODE_W-1:0] code_mem   [SYMBOL_COUNT];
	logic [CLEN_W-1:0] len_mem    [SYMBOL_COUNT];

	logic [NW-1:0]     cnt_q, made_q, addr_q, cur_q;
	logic [SYM_W-1:0]  sym_q;
	logic [FREQ_W-1:0] rd_w_s1;
	logic [SYM_W-1:0]  rd_m_s1;
	logic              rd_a_s1;
	logic [NW-1:0]     idx_s1;
	logic              vld_s1;
	logic [FREQ_W-1:0] first_w_q, second_w_q;
	logic [SYM_W-1:0]  first_m_q, second_m_q;
	logic [NW-1:0]     first_i_q, second_i_q;
	logic              first_v_q, second_v_q;
	logic [NW:0]       pb_rd_q;
	logic [CODE_W-1:0] code_q, code_rd_s1;
	logic [CLEN_W-1:0] len_rd_s1;
	logic [LEN_W-1:0]  len_q;
	logic              ovf_q;
	logic [CODE_W-1:0] code_bits_q;
	logic [CLEN_W-1:0] code_length_q;
	logic              status_q;

	logic              sym_ok, rd_sym_ok, c_before_f, c_before_s;
	logic [FREQ_W-1:0] sum;
	logic [SYM_W-1:0]  new_min;

	assign sym_ok    = {1'b0, in_sym} < 9'(SYMBOL_COUNT);
	assign rd_sym_ok = {1'b0, sym_q} < 9'(SYMBOL_COUNT);

	// Lower weight ranks first; on a tie the greater signed minimum symbol wins.
	assign c_before_f = (rd_w_s1 < first_w_q) ||
		((rd_w_s1 == first_w_q) && ($signed(rd_m_s1) > $signed(first_m_q)));
	assign c_before_s = (rd_w_s1 < second_w_q) ||
		((rd_w_s1 == second_w_q) && ($signed(rd_m_s1) > $signed(second_m_q)));

	assign sum     = first_w_q + second_w_q;
	assign new_min = ($signed(first_m_q) < $signed(second_m_q)) ? first_m_q : second_m_q;

	assign stat.cnt_last   = cnt_q == NW'(SYMBOL_COUNT - 1);
	assign stat.scan_last  = addr_q == (made_q - NW'(1));
	assign stat.merge_last = made_q == NW'(ROOT);
	assign stat.walk_root  = pb_rd_q[NW:1] == NW'(ROOT);

	always_ff @(posedge clk) begin
		if (cmd.op == OP_WR_FREQ && sym_ok) begin
			weight_mem[NW'(in_sym)] <= in_freq;
		end else if (cmd.op == OP_WR_NEW) begin
			weight_mem[made_q] <= sum;
		end
		rd_w_s1 <= weight_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_INIT) begin
			minsym_mem[cnt_q] <= SYM_W'(cnt_q);
		end else if (cmd.op == OP_WR_NEW) begin
			minsym_mem[made_q] <= new_min;
		end
		rd_m_s1 <= minsym_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_INIT:      active_mem[cnt_q] <= 1'b1;
			OP_WR_FIRST:  active_mem[first_i_q] <= 1'b0;
			OP_WR_SECOND: active_mem[second_i_q] <= 1'b0;
			OP_WR_NEW:    active_mem[made_q] <= 1'b1;
			default: ;
		endcase
		rd_a_s1 <= active_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_WR_FIRST) begin
			pb_mem[first_i_q] <= {made_q, 1'b0};
		end else if (cmd.op == OP_WR_SECOND) begin
			pb_mem[second_i_q] <= {made_q, 1'b1};
		end
		pb_rd_q <= pb_mem[cur_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_WALK_STORE) begin
			if (len_q > LEN_W'(MAX_CODE_LEN)) begin
				code_mem[cnt_q[SW-1:0]] <= '0;
				len_mem[cnt_q[SW-1:0]]  <= '0;
			end else begin
				code_mem[cnt_q[SW-1:0]] <= code_q;
				len_mem[cnt_q[SW-1:0]]  <= CLEN_W'(len_q);
			end
		end
		code_rd_s1 <= code_mem[sym_q[SW-1:0]];
		len_rd_s1  <= len_mem[sym_q[SW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			first_v_q  <= 1'b0;
			second_v_q <= 1'b0;
			ovf_q      <= 1'b0;
		end else begin
			vld_s1 <= cmd.op == OP_SCAN;
			if (cmd.op == OP_MERGE_START) begin
				first_v_q  <= 1'b0;
				second_v_q <= 1'b0;
			end else if (vld_s1 && rd_a_s1) begin
				if (!first_v_q || c_before_f) begin
					first_v_q  <= 1'b1;
					second_v_q <= first_v_q;
				end else if (!second_v_q || c_before_s) begin
					second_v_q <= 1'b1;
				end
			end
			if (cmd.op == OP_INIT_START) begin
				ovf_q <= 1'b0;
			end else if (cmd.op == OP_WALK_STORE && len_q > LEN_W'(MAX_CODE_LEN)) begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		if (cmd.capture) begin
			sym_q <= in_sym;
		end
		if (vld_s1 && rd_a_s1 && cmd.op != OP_MERGE_START) begin
			if (!first_v_q || c_before_f) begin
				second_w_q <= first_w_q;
				second_m_q <= first_m_q;
				second_i_q <= first_i_q;
				first_w_q  <= rd_w_s1;
				first_m_q  <= rd_m_s1;
				first_i_q  <= idx_s1;
			end else if (!second_v_q || c_before_s) begin
				second_w_q <= rd_w_s1;
				second_m_q <= rd_m_s1;
				second_i_q <= idx_s1;
			end
		end
		case (cmd.op)
			OP_INIT_START: begin
				cnt_q  <= '0;
				made_q <= NW'(SYMBOL_COUNT);
			end
			OP_INIT: cnt_q <= cnt_q + NW'(1);
			OP_MERGE_START: begin
				cnt_q  <= '0;
				addr_q <= '0;
			end
			OP_SCAN:   addr_q <= addr_q + NW'(1);
			OP_WR_NEW: made_q <= made_q + NW'(1);
			OP_WALK_START: begin
				cur_q  <= cnt_q;
				code_q <= '0;
				len_q  <= '0;
			end
			OP_WALK_USE: begin
				if (len_q < LEN_W'(CODE_W)) begin
					code_q[len_q[5:0]] <= pb_rd_q[0];
				end
				len_q <= len_q + LEN_W'(1);
				cur_q <= pb_rd_q[NW:1];
			end
			OP_WALK_STORE: cnt_q <= cnt_q + NW'(1);
			OP_OUT: begin
				code_bits_q   <= rd_sym_ok ? code_rd_s1 : '0;
				code_length_q <= rd_sym_ok ? len_rd_s1 : '0;
				status_q      <= ovf_q;
			end
			default: ;
		endcase
	end

	assign code_bits   = code_bits_q;
	assign code_length = code_length_q;
	assign status      = status_q;

endmodule

@@ sv/hctb_ctrl.sv @@
// Controller of the Huffman code table builder: command sequencing for
// write, build and read, and the output valid flag. Depends on hctb_pkg.
module hctb_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [hctb_pkg::FUNC_W-1:0] in_func,
	output logic                        in_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	output hctb_pkg::dp_cmd_t           cmd,
	input  hctb_pkg::dp_stat_t          stat
);
	import hctb_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_DELIVER, ST_INIT, ST_MSTART, ST_SCAN, ST_FLUSH,
		ST_WRF, ST_WRS, ST_WRN, ST_WSTART, ST_WRD, ST_WUSE, ST_WSTORE
	} state_t;

	state_t state_q;
	logic   valid_q;
	logic   accept, out_free;

	assign in_ready  = state_q == ST_IDLE;
	assign accept    = in_valid && in_ready;
	assign out_free  = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_comb begin
		cmd.capture = accept;
		cmd.op      = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_func == FUNC_WRITE) begin
					cmd.op = OP_WR_FREQ;
				end else if (accept && in_func == FUNC_BUILD) begin
					cmd.op = OP_INIT_START;
				end
			end
			ST_DELIVER: cmd.op = out_free ? OP_OUT : OP_NONE;
			ST_INIT:    cmd.op = OP_INIT;
			ST_MSTART:  cmd.op = OP_MERGE_START;
			ST_SCAN:    cmd.op = OP_SCAN;
			ST_WRF:     cmd.op = OP_WR_FIRST;
			ST_WRS:     cmd.op = OP_WR_SECOND;
			ST_WRN:     cmd.op = OP_WR_NEW;
			ST_WSTART:  cmd.op = OP_WALK_START;
			ST_WUSE:    cmd.op = OP_WALK_USE;
			ST_WSTORE:  cmd.op = OP_WALK_STORE;
			default:    cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			if (valid_q && out_ready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && in_func == FUNC_BUILD) begin
						state_q <= ST_INIT;
					end else if (accept && in_func == FUNC_READ) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_DELIVER;
				ST_DELIVER: begin
					if (out_free) begin
						valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_INIT:   if (stat.cnt_last) state_q <= ST_MSTART;
				ST_MSTART: state_q <= ST_SCAN;
				ST_SCAN:   if (stat.scan_last) state_q <= ST_FLUSH;
				ST_FLUSH:  state_q <= ST_WRF;
				ST_WRF:    state_q <= ST_WRS;
				ST_WRS:    state_q <= ST_WRN;
				ST_WRN:    state_q <= stat.merge_last ? ST_WSTART : ST_MSTART;
				ST_WSTART: state_q <= ST_WRD;
				ST_WRD:    state_q <= ST_WUSE;
				ST_WUSE:   state_q <= stat.walk_root ? ST_WSTORE : ST_WRD;
				ST_WSTORE: state_q <= stat.cnt_last ? ST_IDLE : ST_WSTART;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ sv/huffman_code_table_builder.sv @@
// Top level of the Huffman code table builder: stream ports, controller
// and datapath. Depends on hctb_pkg, hctb_ctrl and hctb_datapath.
//
// The block takes one command transaction at a time. A write (func 0) stores
// a 64-bit frequency for one symbol. A read (func 2) returns one result
// transaction with the symbol's code, its length and the overflow flag of
// the last build; it passes through the captured symbol, the code memory
// read register and the result register, and a new command is taken while
// that result waits. A build (func 1) runs a sequencer over the node
// memories: an initialization pass over all SYMBOL_COUNT leaves, then
// SYMBOL_COUNT-1 merges, each scanning every node made so far through one
// registered memory read port, then a code walk from every leaf to the root.
// The leaf-to-root walk writes the first branch bit into bit 0 of the code,
// its least significant position. Codes longer than MAX_CODE_LEN are stored
// as zero with length zero and set the status flag. Reads of symbols at or
// above SYMBOL_COUNT return a zero code and length.
module huffman_code_table_builder #(
	parameter int SYMBOL_COUNT = 256,
	parameter int MAX_CODE_LEN = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // symbol[7:0], frequency[71:8]
	input  logic [1:0]  s_tuser,  // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // code_bits[63:0], code_length[70:64], zero[71]
	output logic        m_tuser   // status[0]
);
	import hctb_pkg::*;

	dp_cmd_t           cmd;
	dp_stat_t          stat;
	logic [CODE_W-1:0] code_bits;
	logic [CLEN_W-1:0] code_length;
	logic              status;

	hctb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_func   (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	hctb_datapath #(
		.SYMBOL_COUNT (SYMBOL_COUNT),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_sym      (s_tdata[7:0]),
		.in_freq     (s_tdata[71:8]),
		.code_bits   (code_bits),
		.code_length (code_length),
		.status      (status)
	);

	assign m_tdata = {1'b0, code_length, code_bits};
	assign m_tuser = status;

	// A build transaction keeps the input closed on the following cycle.
	a_build_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == FUNC_BUILD) |=> !s_tready)
		else $error("input open right after a build transaction");

	// A write transaction never produces a result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == FUNC_WRITE && !m_tvalid) |=> !m_tvalid)
		else $error("result raised by a write transaction");

	// A read transaction drives no datapath write.
	a_read_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == FUNC_READ) |-> (cmd.op == OP_NONE))
		else $error("datapath operation issued on a read transaction");

endmodule
